### rtl/ilf_pkg.sv
`default_nettype none

package ilf_pkg;

    localparam int GRID_COLS = 256;
    localparam int GRID_ROWS = 256;
    localparam int CELLS     = GRID_COLS * GRID_ROWS;
    localparam int IDX_W     = $clog2(CELLS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Quotient bits of the two long divisions.
    localparam int SCALE_STAGES = 16;
    localparam int T_STAGES     = 21;

    localparam logic [7:0]  INTENSITY_INIT = 8'd128;
    localparam logic [15:0] SCALE_MID      = 16'h8000;
    localparam logic [15:0] SCALE_FULL     = 16'hFF00;
    localparam logic [16:0] LOG2E_Q16      = 17'd94548;
    localparam logic [20:0] T_CAP          = 21'h100000;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [2:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [2:0] CFG_CELLS_PER_M   = 3'd2;
    localparam logic [2:0] CFG_GEO_WEIGHT    = 3'd3;
    localparam logic [2:0] CFG_INT_WEIGHT    = 3'd4;
    localparam logic [2:0] CFG_INT_SIGMA     = 3'd5;
    localparam logic [2:0] CFG_RAW_MINIMUM   = 3'd6;
    localparam logic [2:0] CFG_RAW_MAXIMUM   = 3'd7;

    typedef struct packed {
        logic               func;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] observed_raw;
        logic [7:0]         cell_col;
        logic [7:0]         cell_row;
        logic [15:0]        cell_geo;
        logic [7:0]         cell_expected;
    } item_t;

    typedef struct packed {
        logic        out_of_bounds;
        logic [31:0] combined_score;
        logic [7:0]  expected_value;
    } result_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [31:0]        cells_per_meter;
        logic [15:0]        geo_gain;
        logic [15:0]        int_gain;
        logic [15:0]        int_spread;
        logic signed [31:0] raw_minimum;
        logic signed [31:0] raw_maximum;
    } cfg_t;

    // Word handed from the front end to the back end through the queue.
    typedef struct packed {
        logic             is_query;
        logic             oob;
        logic [IDX_W-1:0] idx;
        logic [15:0]      geo;
        logic [7:0]       expected;
        logic [15:0]      scaled;
    } fb_word_t;

    typedef struct packed {
        logic        valid;
        logic        oob;
        logic [15:0] scaled;
        logic [7:0]  expected;
        logic [15:0] geo;
    } gauss_in_t;

    typedef struct packed {
        logic        valid;
        logic        oob;
        logic [16:0] lik;
        logic [7:0]  expected;
        logic [15:0] geo;
    } gauss_out_t;

    // 2^(-k/16) in Q1.16, k = 0..16.
    function automatic logic [16:0] pow2_neg(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/intensity_likelihood_field_unit.sv
`default_nettype none

// Channel    Ports                          Word
// command    start, busy, item              item_t: load a cell or query a position
// result     done, result                   result_t: one word per query, none per load
// config     cfg_write, cfg_index, cfg_data eight registers, one written per cfg_write
//
// A command is taken in every cycle in which start is high and busy is low.
// Each query passes through two long divisions (16 and 21 quotient bits,
// one bit per stage) on its way to the result.
// After reset, busy stays high while the intensity table is swept to 128.
// Results come as a one-cycle strobe on done and cannot be held off.

module intensity_likelihood_field_unit import ilf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    output logic        done,
    output result_t     result,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t     cfg_reg;
    logic     accept;
    logic     push, pop, empty, almost_full, clearing;
    fb_word_t push_word, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x        <= 32'sd0;
            cfg_reg.origin_y        <= 32'sd0;
            cfg_reg.cells_per_meter <= 32'd1310720;
            cfg_reg.geo_gain        <= 16'd256;
            cfg_reg.int_gain        <= 16'd256;
            cfg_reg.int_spread      <= 16'd5120;
            cfg_reg.raw_minimum     <= 32'sd0;
            cfg_reg.raw_maximum     <= 32'sd16711680;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:    cfg_reg.origin_x        <= cfg_data;
                CFG_ORIGIN_Y:    cfg_reg.origin_y        <= cfg_data;
                CFG_CELLS_PER_M: cfg_reg.cells_per_meter <= cfg_data;
                CFG_GEO_WEIGHT:  cfg_reg.geo_gain        <= cfg_data[15:0];
                CFG_INT_WEIGHT:  cfg_reg.int_gain        <= cfg_data[15:0];
                CFG_INT_SIGMA:   cfg_reg.int_spread      <= cfg_data[15:0];
                CFG_RAW_MINIMUM: cfg_reg.raw_minimum     <= cfg_data;
                CFG_RAW_MAXIMUM: cfg_reg.raw_maximum     <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign busy   = clearing || almost_full;
    assign accept = start && !busy;

    ilf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg       (cfg_reg),
        .push      (push),
        .push_word (push_word)
    );

    ilf_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_word   (push_word),
        .pop         (pop),
        .head        (head),
        .empty       (empty),
        .almost_full (almost_full)
    );

    ilf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !done)
        else $error("result word during the clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !push)
        else $error("front end active during the clearing pass");

endmodule

`default_nettype wire

### rtl/ilf_front.sv
`default_nettype none

module ilf_front import ilf_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  item_t    item,
    input  cfg_t     cfg,
    output logic     push,
    output fb_word_t push_word
);

    logic [32:0] dx, dy, ndx, ndy, num_w, den_w;
    logic        range_ok, use_div_w;
    logic [15:0] sfix_w;

    logic             a_valid_reg, a_query_reg, a_negx_reg, a_negy_reg;
    logic             a_use_div_reg, a_load_ok_reg;
    logic [31:0]      a_magx_reg, a_magy_reg, a_num_reg, a_den_reg;
    logic [15:0]      a_sfix_reg, a_geo_reg;
    logic [7:0]       a_exp_reg;
    logic [IDX_W-1:0] a_idx_reg;

    logic [63:0]      prodx, prody;
    logic [47:0]      nprod;
    logic             oobx, ooby;
    logic [IDX_W-1:0] qidx;
    fb_word_t         word0;

    logic [SCALE_STAGES:0] d_valid_reg;
    fb_word_t    d_word_reg    [SCALE_STAGES+1];
    logic [31:0] d_rem_reg     [SCALE_STAGES+1];
    logic [15:0] d_low_reg     [SCALE_STAGES+1];
    logic [15:0] d_q_reg       [SCALE_STAGES+1];
    logic [31:0] d_den_reg     [SCALE_STAGES+1];
    logic        d_use_div_reg [SCALE_STAGES+1];
    logic [15:0] d_sfix_reg    [SCALE_STAGES+1];

    logic [32:0] rem2_w    [SCALE_STAGES];
    logic        ge_w      [SCALE_STAGES];
    logic [31:0] rem_next  [SCALE_STAGES];
    logic [15:0] q_next    [SCALE_STAGES];
    logic [15:0] low_next  [SCALE_STAGES];

    // Position offsets and the classification of the raw intensity.
    always_comb
    begin
        dx    = {item.pos_x[31], item.pos_x} - {cfg.origin_x[31], cfg.origin_x};
        dy    = {item.pos_y[31], item.pos_y} - {cfg.origin_y[31], cfg.origin_y};
        ndx   = 33'd0 - dx;
        ndy   = 33'd0 - dy;
        num_w = {item.observed_raw[31], item.observed_raw}
              - {cfg.raw_minimum[31], cfg.raw_minimum};
        den_w = {cfg.raw_maximum[31], cfg.raw_maximum}
              - {cfg.raw_minimum[31], cfg.raw_minimum};
        range_ok  = $signed(cfg.raw_maximum) > $signed(cfg.raw_minimum);
        use_div_w = 1'b0;
        sfix_w    = 16'd0;
        if (!range_ok)
        begin
            sfix_w = SCALE_MID;
        end
        else if (num_w[32] || num_w == 33'd0)
        begin
            sfix_w = 16'd0;
        end
        else if ($signed(num_w) >= $signed(den_w))
        begin
            sfix_w = SCALE_FULL;
        end
        else
        begin
            use_div_w = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        a_query_reg   <= (item.func == FUNC_QUERY);
        a_negx_reg    <= dx[32];
        a_negy_reg    <= dy[32];
        a_magx_reg    <= dx[32] ? ndx[31:0] : dx[31:0];
        a_magy_reg    <= dy[32] ? ndy[31:0] : dy[31:0];
        a_num_reg     <= num_w[31:0];
        a_den_reg     <= den_w[31:0];
        a_use_div_reg <= use_div_w;
        a_sfix_reg    <= sfix_w;
        a_geo_reg     <= item.cell_geo;
        a_exp_reg     <= item.cell_expected;
        a_load_ok_reg <= (int'(item.cell_col) < GRID_COLS) && (int'(item.cell_row) < GRID_ROWS);
        a_idx_reg     <= IDX_W'(int'(item.cell_row) * GRID_COLS + int'(item.cell_col));
    end

    // Cell lookup and the numerator of the intensity scaling.
    always_comb
    begin
        prodx = {32'd0, a_magx_reg} * {32'd0, cfg.cells_per_meter};
        prody = {32'd0, a_magy_reg} * {32'd0, cfg.cells_per_meter};
        nprod = {16'd0, a_num_reg} * {32'd0, SCALE_FULL};
        oobx  = (a_negx_reg && prodx != 64'd0) || (prodx[63:32] >= 32'(GRID_COLS));
        ooby  = (a_negy_reg && prody != 64'd0) || (prody[63:32] >= 32'(GRID_ROWS));
        qidx  = IDX_W'(prody[63:32] * 32'(GRID_COLS) + prodx[63:32]);
        word0.is_query = a_query_reg;
        word0.oob      = a_query_reg && (oobx || ooby);
        word0.idx      = a_query_reg ? qidx : a_idx_reg;
        word0.geo      = a_geo_reg;
        word0.expected = a_exp_reg;
        word0.scaled   = 16'd0;
    end

    // One quotient bit per stage; when the quotient is used, the partial remainder stays below the divisor.
    always_comb
    begin
        for (int i = 0; i < SCALE_STAGES; i++)
        begin
            rem2_w[i]   = {d_rem_reg[i], d_low_reg[i][15]};
            ge_w[i]     = rem2_w[i] >= {1'b0, d_den_reg[i]};
            rem_next[i] = ge_w[i] ? 32'(rem2_w[i] - {1'b0, d_den_reg[i]}) : rem2_w[i][31:0];
            q_next[i]   = {d_q_reg[i][14:0], ge_w[i]};
            low_next[i] = {d_low_reg[i][14:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= '0;
        end
        else
        begin
            // Loads outside the grid are dropped here.
            d_valid_reg <= {d_valid_reg[SCALE_STAGES-1:0],
                            a_valid_reg && (a_query_reg || a_load_ok_reg)};
        end
    end

    always_ff @(posedge clk)
    begin
        d_word_reg[0]    <= word0;
        d_rem_reg[0]     <= nprod[47:16];
        d_low_reg[0]     <= nprod[15:0];
        d_q_reg[0]       <= 16'd0;
        d_den_reg[0]     <= a_den_reg;
        d_use_div_reg[0] <= a_use_div_reg;
        d_sfix_reg[0]    <= a_sfix_reg;
        for (int i = 0; i < SCALE_STAGES; i++)
        begin
            d_word_reg[i+1]    <= d_word_reg[i];
            d_rem_reg[i+1]     <= rem_next[i];
            d_low_reg[i+1]     <= low_next[i];
            d_q_reg[i+1]       <= q_next[i];
            d_den_reg[i+1]     <= d_den_reg[i];
            d_use_div_reg[i+1] <= d_use_div_reg[i];
            d_sfix_reg[i+1]    <= d_sfix_reg[i];
        end
    end

    always_comb
    begin
        push             = d_valid_reg[SCALE_STAGES];
        push_word        = d_word_reg[SCALE_STAGES];
        push_word.scaled = d_use_div_reg[SCALE_STAGES] ? d_q_reg[SCALE_STAGES]
                                                       : d_sfix_reg[SCALE_STAGES];
    end

endmodule

`default_nettype wire

### rtl/ilf_queue.sv
`default_nettype none

module ilf_queue import ilf_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  fb_word_t push_word,
    input  logic     pop,
    output fb_word_t head,
    output logic     empty,
    output logic     almost_full
);

    fb_word_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head        = mem_reg[rd_ptr_reg];
    assign empty       = (count_reg == '0);
    assign almost_full = (count_reg >= QCNT_W'(QUEUE_DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && count_reg == QCNT_W'(QUEUE_DEPTH)))
        else $error("word pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && count_reg == '0))
        else $error("word popped from an empty queue");

endmodule

`default_nettype wire

### rtl/ilf_gauss.sv
`default_nettype none

module ilf_gauss import ilf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] sigma,
    input  gauss_in_t   g_in,
    output gauss_out_t  g_out
);

    logic [16:0] diff;
    logic [15:0] mag, sig1;

    logic        g1_valid_reg, g1_oob_reg;
    logic [15:0] g1_geo_reg, g1_mag_reg;
    logic [7:0]  g1_exp_reg;
    logic [31:0] g1_sq_reg;

    logic        g2_valid_reg, g2_oob_reg;
    logic [15:0] g2_geo_reg;
    logic [7:0]  g2_exp_reg;
    logic [31:0] g2_msq_reg;
    logic [32:0] g2_den_reg;

    logic        sat0;

    logic [T_STAGES:0] t_valid_reg;
    logic        t_oob_reg [T_STAGES+1];
    logic [15:0] t_geo_reg [T_STAGES+1];
    logic [7:0]  t_exp_reg [T_STAGES+1];
    logic        t_sat_reg [T_STAGES+1];
    logic [32:0] t_den_reg [T_STAGES+1];
    logic [32:0] t_rem_reg [T_STAGES+1];
    logic [20:0] t_low_reg [T_STAGES+1];
    logic [20:0] t_q_reg   [T_STAGES+1];

    logic [33:0] rem2_w   [T_STAGES];
    logic        ge_w     [T_STAGES];
    logic [32:0] rem_next [T_STAGES];
    logic [20:0] q_next   [T_STAGES];
    logic [20:0] low_next [T_STAGES];

    logic [20:0] t_capped;
    logic [37:0] u_w;

    logic        e1_valid_reg, e1_oob_reg;
    logic [15:0] e1_geo_reg, e1_f_reg;
    logic [7:0]  e1_exp_reg;
    logic [5:0]  e1_n_reg;

    logic [16:0] tk_w, tk1_w;
    logic [11:0] dt_w;
    logic [23:0] interp_w;

    logic        e2_valid_reg, e2_oob_reg;
    logic [15:0] e2_geo_reg;
    logic [7:0]  e2_exp_reg;
    logic [5:0]  e2_n_reg;
    logic [16:0] e2_tk_reg;
    logic [11:0] e2_psh_reg;

    logic [16:0] m_w;

    logic        e3_valid_reg, e3_oob_reg;
    logic [15:0] e3_geo_reg;
    logic [7:0]  e3_exp_reg;
    logic [16:0] e3_lik_reg;

    always_comb
    begin
        diff = {1'b0, g_in.scaled} - {1'b0, g_in.expected, 8'd0};
        mag  = diff[16] ? 16'(17'd0 - diff) : diff[15:0];
        sig1 = (sigma == 16'd0) ? 16'd1 : sigma;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
            t_valid_reg  <= '0;
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
            e3_valid_reg <= 1'b0;
        end
        else
        begin
            g1_valid_reg <= g_in.valid;
            g2_valid_reg <= g1_valid_reg;
            t_valid_reg  <= {t_valid_reg[T_STAGES-1:0], g2_valid_reg};
            e1_valid_reg <= t_valid_reg[T_STAGES];
            e2_valid_reg <= e1_valid_reg;
            e3_valid_reg <= e2_valid_reg;
        end
    end

    // Squared difference and twice the squared sigma.
    always_ff @(posedge clk)
    begin
        g1_oob_reg <= g_in.oob;
        g1_geo_reg <= g_in.geo;
        g1_exp_reg <= g_in.expected;
        g1_mag_reg <= mag;
        g1_sq_reg  <= {16'd0, sig1} * {16'd0, sig1};

        g2_oob_reg <= g1_oob_reg;
        g2_geo_reg <= g1_geo_reg;
        g2_exp_reg <= g1_exp_reg;
        g2_msq_reg <= {16'd0, g1_mag_reg} * {16'd0, g1_mag_reg};
        g2_den_reg <= {g1_sq_reg, 1'b0};
    end

    // The exponent is capped at 16.0, so a quotient of 2^21 or more only sets the cap.
    assign sat0 = {6'd0, g2_msq_reg[31:5]} >= g2_den_reg;

    always_comb
    begin
        for (int i = 0; i < T_STAGES; i++)
        begin
            rem2_w[i]   = {t_rem_reg[i], t_low_reg[i][T_STAGES-1]};
            ge_w[i]     = rem2_w[i] >= {1'b0, t_den_reg[i]};
            rem_next[i] = ge_w[i] ? 33'(rem2_w[i] - {1'b0, t_den_reg[i]}) : rem2_w[i][32:0];
            q_next[i]   = {t_q_reg[i][T_STAGES-2:0], ge_w[i]};
            low_next[i] = {t_low_reg[i][T_STAGES-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        t_oob_reg[0] <= g2_oob_reg;
        t_geo_reg[0] <= g2_geo_reg;
        t_exp_reg[0] <= g2_exp_reg;
        t_sat_reg[0] <= sat0;
        t_den_reg[0] <= g2_den_reg;
        t_rem_reg[0] <= sat0 ? 33'd0 : {6'd0, g2_msq_reg[31:5]};
        t_low_reg[0] <= {g2_msq_reg[4:0], 16'd0};
        t_q_reg[0]   <= 21'd0;
        for (int i = 0; i < T_STAGES; i++)
        begin
            t_oob_reg[i+1] <= t_oob_reg[i];
            t_geo_reg[i+1] <= t_geo_reg[i];
            t_exp_reg[i+1] <= t_exp_reg[i];
            t_sat_reg[i+1] <= t_sat_reg[i];
            t_den_reg[i+1] <= t_den_reg[i];
            t_rem_reg[i+1] <= rem_next[i];
            t_low_reg[i+1] <= low_next[i];
            t_q_reg[i+1]   <= q_next[i];
        end
    end

    always_comb
    begin
        t_capped = (t_sat_reg[T_STAGES] || t_q_reg[T_STAGES] > T_CAP) ? T_CAP
                                                                      : t_q_reg[T_STAGES];
        u_w      = {17'd0, t_capped} * {21'd0, LOG2E_Q16};
    end

    // exp(-t) = 2^(-u): interpolate the fraction in a 17-entry table, shift by the integer.
    always_comb
    begin
        tk_w     = pow2_neg({1'b0, e1_f_reg[15:12]});
        tk1_w    = pow2_neg({1'b0, e1_f_reg[15:12]} + 5'd1);
        dt_w     = 12'(tk_w - tk1_w);
        interp_w = {12'd0, dt_w} * {12'd0, e1_f_reg[11:0]};
        m_w      = e2_tk_reg - {5'd0, e2_psh_reg};
    end

    always_ff @(posedge clk)
    begin
        e1_oob_reg <= t_oob_reg[T_STAGES];
        e1_geo_reg <= t_geo_reg[T_STAGES];
        e1_exp_reg <= t_exp_reg[T_STAGES];
        e1_n_reg   <= u_w[37:32];
        e1_f_reg   <= u_w[31:16];

        e2_oob_reg <= e1_oob_reg;
        e2_geo_reg <= e1_geo_reg;
        e2_exp_reg <= e1_exp_reg;
        e2_n_reg   <= e1_n_reg;
        e2_tk_reg  <= tk_w;
        e2_psh_reg <= interp_w[23:12];

        e3_oob_reg <= e2_oob_reg;
        e3_geo_reg <= e2_geo_reg;
        e3_exp_reg <= e2_exp_reg;
        e3_lik_reg <= (e2_n_reg >= 6'd17) ? 17'd0 : (m_w >> e2_n_reg);
    end

    always_comb
    begin
        g_out.valid    = e3_valid_reg;
        g_out.oob      = e3_oob_reg;
        g_out.lik      = e3_lik_reg;
        g_out.expected = e3_exp_reg;
        g_out.geo      = e3_geo_reg;
    end

endmodule

`default_nettype wire

### rtl/ilf_back.sv
`default_nettype none

module ilf_back import ilf_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  fb_word_t head,
    input  logic     empty,
    output logic     pop,
    output logic     clearing,
    output logic     done,
    output result_t  result
);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_addr_reg;

    logic [15:0] geo_mem [CELLS];
    logic [7:0]  int_mem [CELLS];

    logic             load_we, int_we;
    logic [IDX_W-1:0] int_addr;
    logic [7:0]       int_wdata;
    logic [15:0]      geo_rd_reg;
    logic [7:0]       int_rd_reg;

    logic        r_valid_reg, r_oob_reg;
    logic [15:0] r_scaled_reg;

    gauss_in_t  g_in;
    gauss_out_t g_out;

    logic        c_valid_reg, c_oob_reg;
    logic [7:0]  c_exp_reg;
    logic [31:0] c_geo_term_reg;
    logic [32:0] c_int_term_reg;
    logic [33:0] sum_w;

    logic    done_reg;
    result_t result_reg;

    // After reset every intensity entry is swept to its initial value, one per cycle.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == IDX_W'(CELLS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    assign clearing = (state_reg == ST_CLEAR);
    assign pop      = !clearing && !empty;

    always_comb
    begin
        load_we   = pop && !head.is_query;
        int_we    = clearing || load_we;
        int_addr  = clearing ? clr_addr_reg : head.idx;
        int_wdata = clearing ? INTENSITY_INIT : head.expected;
    end

    // Loads and queries share one port per table and keep their order,
    // so a query always sees every earlier load.
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            geo_mem[head.idx] <= head.geo;
        end
        geo_rd_reg <= geo_mem[head.idx];
    end

    always_ff @(posedge clk)
    begin
        if (int_we)
        begin
            int_mem[int_addr] <= int_wdata;
        end
        int_rd_reg <= int_mem[int_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            r_valid_reg <= pop && head.is_query;
            c_valid_reg <= g_out.valid;
            done_reg    <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r_oob_reg    <= head.oob;
        r_scaled_reg <= head.scaled;
    end

    always_comb
    begin
        g_in.valid    = r_valid_reg;
        g_in.oob      = r_oob_reg;
        g_in.scaled   = r_scaled_reg;
        g_in.expected = int_rd_reg;
        g_in.geo      = geo_rd_reg;
    end

    ilf_gauss u_gauss (
        .clk   (clk),
        .rst_n (rst_n),
        .sigma (cfg.int_spread),
        .g_in  (g_in),
        .g_out (g_out)
    );

    always_ff @(posedge clk)
    begin
        c_oob_reg      <= g_out.oob;
        c_exp_reg      <= g_out.expected;
        c_geo_term_reg <= {16'd0, cfg.geo_gain} * {16'd0, g_out.geo};
        c_int_term_reg <= {17'd0, cfg.int_gain} * {16'd0, g_out.lik};
    end

    // The weighted sum stays below 2^34, so after the shift it always fits in the
    // 32-bit score.
    assign sum_w = {2'd0, c_geo_term_reg} + {1'd0, c_int_term_reg};

    always_ff @(posedge clk)
    begin
        result_reg.out_of_bounds  <= c_oob_reg;
        result_reg.combined_score <= c_oob_reg ? 32'd0 : {6'd0, sum_w[33:8]};
        result_reg.expected_value <= c_oob_reg ? 8'd0 : c_exp_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.out_of_bounds) |->
            (result_reg.combined_score == 32'd0 && result_reg.expected_value == 8'd0))
        else $error("out-of-bounds result carries a score");

    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !r_valid_reg)
        else $error("table read while the clearing pass runs");

endmodule

`default_nettype wire
